// File: design/sawil_pkg.sv
// Shared constants, register codes and a saturation helper for the setpoint average core.
// No dependencies; compiled first.
`default_nettype none

package sawil_pkg;

    localparam int TAPS_DEFAULT     = 16;
    localparam int ADC_BITS_DEFAULT = 12;

    localparam int RAW_W    = 12;
    localparam int VAL_W    = 32;
    localparam int LIMIT_W  = 16;
    localparam int MUL_A_W  = 16;
    localparam int PROD_W   = MUL_A_W + VAL_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 136;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FRACTION = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd62259;

    function automatic logic [VAL_W-1:0] sat32(input logic [PROD_W-1:0] p);
        logic [VAL_W-1:0] r;
        r = (|p[PROD_W-1:VAL_W]) ? {VAL_W{1'b1}} : p[VAL_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/setpoint_average_with_input_limit_core.sv
// Setpoint averaging filter with input-voltage limit, top level.
// Depends on sawil_pkg and sawil_ram.
//
// Usage:
//   One control tick is one transfer on the s_ channel: four ADC codes and
//   two active-low buttons. Each tick gives exactly one transfer on the m_
//   channel: run flag, off event, filtered setpoint, input voltage, held DC
//   voltage and load current, and the limit flag.
//   Gains and the limit fraction are written on the cfg_ port; write them only
//   while idle. The block itself does not enforce this. With TAPS a power of
//   two each divide by TAPS is a shift; a tick in which the limit reloads the
//   filter adds one more pass through the divide state. For other TAPS each
//   divide by TAPS is a reciprocal multiply on the shared unit; the limit path
//   divides twice. The single 16x32 multiplier makes five passes per tick plus
//   two per divide. s_tready is high only between ticks. A result waits in the
//   output register; when the receiver stalls, the next tick is still taken and
//   its result holds in the sequencer until the register frees.
//   Reset clears run flag, ring (per-entry valid bits), ring sum, position,
//   held values and registers (limit fraction returns to about 0.95).
`default_nettype none

module setpoint_average_with_input_limit_core #(
    parameter int TAPS     = sawil_pkg::TAPS_DEFAULT,
    parameter int ADC_BITS = sawil_pkg::ADC_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [sawil_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sawil_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // setpoint_raw, input_raw, voltage_raw, current_raw, on_button_n, off_button_n
    input  wire logic [sawil_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // running, off_event, setpoint_volts, input_volts, dc_volts, load_amps, limited
    output logic      [sawil_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int RW      = sawil_pkg::RAW_W;
    localparam int VW      = sawil_pkg::VAL_W;
    localparam int LW      = sawil_pkg::LIMIT_W;
    localparam int MA_W    = sawil_pkg::MUL_A_W;
    localparam int PW      = sawil_pkg::PROD_W;
    localparam int POS_W   = $clog2(TAPS);
    localparam int DIV_STEPS = 4;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int POST_SH = (POS_W > 0) ? POS_W - 1 : 0;
    localparam bit TAPS_POW2 = ((TAPS & (TAPS - 1)) == 0);
    // reciprocal for divide by TAPS: t1 = (x * RECIP) >> 32,
    // q = (t1 + ((x - t1) >> 1)) >> (clog2(TAPS) - 1)
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << VW) * ((64'd1 << POS_W) - 64'(TAPS))) / 64'(TAPS) + 64'd1;
    localparam logic [VW-1:0] RECIP = VW'(RECIP_WIDE);
    localparam logic [MA_W-1:0] CODE_MASK = MA_W'((33'd1 << ADC_BITS) - 33'd1);
    localparam int OUT_PAD = sawil_pkg::OUT_TDATA_W - (4 * VW + 3);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL_SP  = 9'b000000010,
        ST_MUL_IN  = 9'b000000100,
        ST_MUL_DC  = 9'b000001000,
        ST_MUL_CUR = 9'b000010000,
        ST_SUB     = 9'b000100000,
        ST_DIV     = 9'b001000000,
        ST_CMP     = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [VW-1:0] sp_gain_reg, in_gain_reg, v_gain_reg, c_gain_reg;
    logic [LW-1:0] limit_reg;

    logic             run_reg, run_next;
    logic             off_reg, off_next;
    logic             lim_reg, lim_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VW-1:0]    sum_reg, sum_next;
    logic [VW-1:0]    held_dc_reg, held_dc_next;
    logic [VW-1:0]    held_ld_reg, held_ld_next;
    logic [VW-1:0]    reload_reg, reload_next;
    logic [TAPS-1:0]  valid_reg, valid_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic [RW-1:0]    sp_raw_reg, sp_raw_next;
    logic [RW-1:0]    in_raw_reg, in_raw_next;
    logic [RW-1:0]    v_raw_reg, v_raw_next;
    logic [RW-1:0]    c_raw_reg, c_raw_next;
    logic [VW-1:0]    in_volts_reg, in_volts_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [VW-1:0]    div_quo_reg, div_quo_next;
    logic [PW-1:0]    div_acc_reg, div_acc_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic             div_sel_reg, div_sel_next;

    logic          o_run_reg, o_off_reg, o_lim_reg;
    logic [VW-1:0] o_sp_reg, o_in_reg, o_dc_reg, o_ld_reg;

    logic            mul_en;
    logic [MA_W-1:0] mul_a;
    logic [VW-1:0]   mul_b;
    logic [PW-1:0]   mul_p;
    logic            div_load;
    logic [VW-1:0]   div_load_val;
    logic [VW-1:0]   div_t1;
    logic [VW-1:0]   div_half;
    logic            out_load;
    logic            ram_we, ram_re;
    logic [VW-1:0]   ram_rdata;
    logic [VW-1:0]   old_entry;
    logic [VW:0]     sum_wide;
    logic            accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign div_t1   = div_acc_reg[PW-1:MA_W];
    assign div_half = (div_quo_reg - div_t1) >> 1;
    assign old_entry = valid_reg[pos_reg] ? ram_rdata : reload_reg;
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, div_quo_reg};

    sawil_ram #(
        .WIDTH(VW),
        .DEPTH(TAPS)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pos_reg),
        .wdata(div_quo_reg),
        .re   (ram_re),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        off_next      = off_reg;
        lim_next      = lim_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        held_dc_next  = held_dc_reg;
        held_ld_next  = held_ld_reg;
        reload_next   = reload_reg;
        valid_next    = valid_reg;
        sp_raw_next   = sp_raw_reg;
        in_raw_next   = in_raw_reg;
        v_raw_next    = v_raw_reg;
        c_raw_next    = c_raw_reg;
        in_volts_next = in_volts_reg;
        div_quo_next  = div_quo_reg;
        div_acc_next  = div_acc_reg;
        div_cnt_next  = div_cnt_reg;
        div_sel_next  = div_sel_reg;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_load      = 1'b0;
        div_load_val  = '0;
        out_load      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sp_raw_next = s_tdata[RW-1:0];
                    in_raw_next = s_tdata[2*RW-1:RW];
                    v_raw_next  = s_tdata[3*RW-1:2*RW];
                    c_raw_next  = s_tdata[4*RW-1:3*RW];
                    lim_next    = 1'b0;
                    off_next    = 1'b0;
                    if (!s_tdata[4*RW])
                    begin
                        run_next = 1'b1;
                    end
                    else if (!s_tdata[4*RW+1])
                    begin
                        run_next = 1'b0;
                        off_next = 1'b1;
                    end
                    ram_re     = 1'b1;
                    state_next = ST_MUL_SP;
                end
            end
            ST_MUL_SP:
            begin
                mul_en     = 1'b1;
                mul_a      = MA_W'(sp_raw_reg) & CODE_MASK;
                mul_b      = sp_gain_reg;
                state_next = ST_MUL_IN;
            end
            ST_MUL_IN:
            begin
                div_load     = 1'b1;
                div_load_val = sawil_pkg::sat32(prod_reg);
                div_sel_next = 1'b0;
                mul_en       = 1'b1;
                mul_a        = MA_W'(in_raw_reg) & CODE_MASK;
                mul_b        = in_gain_reg;
                state_next   = ST_MUL_DC;
            end
            ST_MUL_DC:
            begin
                in_volts_next = sawil_pkg::sat32(prod_reg);
                mul_en        = 1'b1;
                mul_a         = MA_W'(v_raw_reg) & CODE_MASK;
                mul_b         = v_gain_reg;
                state_next    = ST_MUL_CUR;
            end
            ST_MUL_CUR:
            begin
                if (run_reg)
                begin
                    held_dc_next = sawil_pkg::sat32(prod_reg);
                end
                mul_en     = 1'b1;
                mul_a      = MA_W'(c_raw_reg) & CODE_MASK;
                mul_b      = c_gain_reg;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                if (run_reg)
                begin
                    held_ld_next = sawil_pkg::sat32(prod_reg);
                end
                sum_next   = (sum_reg >= old_entry) ? sum_reg - old_entry : '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == CNT_W'(DIV_STEPS))
                begin
                    mul_en       = 1'b1;
                    mul_a        = div_quo_reg[VW-1:MA_W];
                    mul_b        = RECIP;
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
                else if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    div_acc_next = prod_reg;
                    mul_en       = 1'b1;
                    mul_a        = div_quo_reg[MA_W-1:0];
                    mul_b        = RECIP;
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
                else if (div_cnt_reg == CNT_W'(DIV_STEPS - 2))
                begin
                    div_acc_next = div_acc_reg + (prod_reg >> MA_W);
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
                else if (div_cnt_reg == CNT_W'(DIV_STEPS - 3))
                begin
                    div_quo_next = (div_t1 + div_half) >> POST_SH;
                    div_cnt_next = div_cnt_reg - CNT_W'(1);
                end
                else if (!div_sel_reg)
                begin
                    ram_we              = 1'b1;
                    valid_next[pos_reg] = 1'b1;
                    sum_next = sum_wide[VW] ? {VW{1'b1}} : sum_wide[VW-1:0];
                    pos_next = (pos_reg == POS_W'(TAPS - 1)) ? '0 : pos_reg + POS_W'(1);
                    mul_en     = 1'b1;
                    mul_a      = MA_W'(limit_reg);
                    mul_b      = in_volts_reg;
                    state_next = ST_CMP;
                end
                else
                begin
                    reload_next = div_quo_reg;
                    valid_next  = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_CMP:
            begin
                if ({sum_reg, {(PW - VW){1'b0}}} > prod_reg)
                begin
                    lim_next     = 1'b1;
                    sum_next     = in_volts_reg;
                    div_load     = 1'b1;
                    div_load_val = in_volts_reg;
                    div_sel_next = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (div_load)
        begin
            if (TAPS_POW2)
            begin
                div_quo_next = div_load_val >> POS_W;
                div_cnt_next = '0;
            end
            else
            begin
                div_quo_next = div_load_val;
                div_cnt_next = CNT_W'(DIV_STEPS);
            end
        end

        prod_next     = mul_en ? mul_p : prod_reg;
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            run_reg      <= 1'b0;
            off_reg      <= 1'b0;
            lim_reg      <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            held_dc_reg  <= '0;
            held_ld_reg  <= '0;
            reload_reg   <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            div_cnt_reg  <= '0;
            sp_gain_reg  <= '0;
            in_gain_reg  <= '0;
            v_gain_reg   <= '0;
            c_gain_reg   <= '0;
            limit_reg    <= sawil_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            off_reg      <= off_next;
            lim_reg      <= lim_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            held_dc_reg  <= held_dc_next;
            held_ld_reg  <= held_ld_next;
            reload_reg   <= reload_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            div_cnt_reg  <= div_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sawil_pkg::CFG_SETPOINT_GAIN:  sp_gain_reg <= cfg_wdata;
                    sawil_pkg::CFG_INPUT_GAIN:     in_gain_reg <= cfg_wdata;
                    sawil_pkg::CFG_VOLTAGE_GAIN:   v_gain_reg  <= cfg_wdata;
                    sawil_pkg::CFG_CURRENT_GAIN:   c_gain_reg  <= cfg_wdata;
                    sawil_pkg::CFG_LIMIT_FRACTION: limit_reg   <= cfg_wdata[LW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sp_raw_reg   <= sp_raw_next;
        in_raw_reg   <= in_raw_next;
        v_raw_reg    <= v_raw_next;
        c_raw_reg    <= c_raw_next;
        in_volts_reg <= in_volts_next;
        prod_reg     <= prod_next;
        div_quo_reg  <= div_quo_next;
        div_acc_reg  <= div_acc_next;
        div_sel_reg  <= div_sel_next;
        if (out_load)
        begin
            o_run_reg <= run_reg;
            o_off_reg <= off_reg;
            o_lim_reg <= lim_reg;
            o_sp_reg  <= sum_reg;
            o_in_reg  <= in_volts_reg;
            o_dc_reg  <= held_dc_reg;
            o_ld_reg  <= held_ld_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, o_lim_reg, o_ld_reg, o_dc_reg, o_in_reg, o_sp_reg,
                       o_off_reg, o_run_reg};

`ifndef SYNTH
    a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("new transfer taken while a tick is in progress");

    a_limit_reloads_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && o_lim_reg |-> o_sp_reg == o_in_reg)
        else $error("limited result does not report input voltage");

    a_off_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && o_off_reg |-> !o_run_reg)
        else $error("off event with run flag still set");

    a_div_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != '0) |-> (state_reg == ST_DIV || state_reg == ST_SUB
                                 || state_reg == ST_MUL_DC || state_reg == ST_MUL_CUR))
        else $error("divider running outside its window");

    a_ring_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> !ram_we && state_reg == ST_CMP)
        else $error("ring written outside the update step");
`endif

endmodule

`default_nettype wire

// File: design/sawil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sawil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
